[hw/rtl/vpa_pkg.sv]
package vpa_pkg;

	localparam int MAX_VARS   = 128;
	localparam int MAX_BLOCKS = 256;
	localparam int POOL_MAX   = 16384;
	localparam int POOL_RESET = 10000;

	localparam int ID_W      = 7;
	localparam int ADDR_W    = 14;
	localparam int SIZE_W    = 15;
	localparam int ID_SPACE  = 2 ** ID_W;
	localparam int BLK_IDX_W = $clog2(MAX_BLOCKS);
	localparam int BLK_CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int VAR_CNT_W = $clog2(MAX_VARS + 1);

	localparam logic [0:0] CFG_FIT  = 1'b0;
	localparam logic [0:0] CFG_POOL = 1'b1;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RESIZE  = 2'd1,
		OP_RELEASE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_EXISTS  = 3'd1,
		ST_FULL    = 3'd2,
		ST_NOSPACE = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [ID_W-1:0]   var_id;
		logic [SIZE_W-1:0] req_size;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] address;
		logic [SIZE_W-1:0] granted_size;
	} res_t;

	typedef struct packed {
		logic              vacant;
		logic [ID_W-1:0]   owner;
		logic [ADDR_W-1:0] base;
		logic [SIZE_W-1:0] len;
	} blk_t;

	typedef enum logic [2:0] {
		CH_HOLD,
		CH_ROT,
		CH_WRITE,
		CH_INS,
		CH_DEL
	} chain_op_t;

	typedef struct packed {
		chain_op_t            op;
		logic [BLK_IDX_W-1:0] pos;
		blk_t                 data;
	} chain_ctl_t;

endpackage

[hw/rtl/variable_pool_allocator.sv]
// channel | direction | handshake           | beat
// in      | in        | in_valid / in_stall | vpa_pkg::req_t
// out     | out       | out_valid/out_stall | vpa_pkg::res_t
// cfg     | in        | cfg_we              | cfg_idx, cfg_data
// A request runs from accept to next accept through one full rotation of the block
// chain to scan it, a decide step and up to three table edits. A resize that moves
// adds a second rotation, a plan step and up to five table edits in all.
// During a scan the cell chain rotates one entry past the head per cycle.
// Reset leaves one vacant block of 10000 bytes; no clearing pass is needed.
// in_stall is high while a request is in work; a result waits in the output register
// under out_stall, the next request is still taken and its result waits in S_DONE.
module variable_pool_allocator (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  vpa_pkg::req_t            in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output vpa_pkg::res_t            out_data,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_idx,
	input  logic [vpa_pkg::SIZE_W-1:0] cfg_data
);

	localparam int IW = vpa_pkg::BLK_IDX_W;
	localparam int CW = vpa_pkg::BLK_CNT_W;
	localparam int SW = vpa_pkg::SIZE_W;
	localparam int AW = vpa_pkg::ADDR_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_PLAN_MOVE,
		S_EDIT,
		S_DONE
	} state_t;

	state_t state_q;

	vpa_pkg::chain_ctl_t ctl;
	vpa_pkg::blk_t       head;

	logic [1:0]    fit_q;
	logic [CW-1:0] blk_cnt_q;
	logic [vpa_pkg::ID_SPACE-1:0] var_valid_q;
	logic [vpa_pkg::VAR_CNT_W-1:0] var_cnt_q;

	vpa_pkg::op_t              op_q;
	logic [vpa_pkg::ID_W-1:0]  id_q;
	logic [SW-1:0]             need_q;

	logic [IW-1:0] j_q;
	logic          pass2_q;

	logic          own_found_q;
	logic [IW-1:0] own_idx_q;
	logic [AW-1:0] own_base_q;
	logic [SW-1:0] own_len_q;
	logic          prev_vac_q;
	logic [AW-1:0] prev_base_q;
	logic [SW-1:0] prev_len_q;
	logic          next_vac_q;
	logic [AW-1:0] next_base_q;
	logic [SW-1:0] next_len_q;
	logic          last_vac_q;
	logic [AW-1:0] last_base_q;
	logic [SW-1:0] last_len_q;

	logic          pick_found_q;
	logic [IW-1:0] pick_idx_q;
	logic [AW-1:0] pick_base_q;
	logic [SW-1:0] pick_len_q;

	logic [IW-1:0] g0_q;
	logic [IW-1:0] g1_q;
	logic [1:0]    dcnt_q;
	logic [SW-1:0] glen_q;
	logic [AW-1:0] gbase_q;

	logic          merge_q;
	logic [1:0]    del_n_q;
	logic          ins_q;
	logic [IW-1:0] ins_pos_q;
	vpa_pkg::blk_t ins_data_q;
	logic          w1_q;
	logic [IW-1:0] w1_pos_q;
	vpa_pkg::blk_t w1_data_q;
	logic          w2_q;
	logic [IW-1:0] w2_pos_q;
	vpa_pkg::blk_t w2_data_q;
	logic          del2_q;
	logic [IW-1:0] del2_pos_q;

	vpa_pkg::res_t res_q;
	vpa_pkg::res_t out_q;
	logic          out_valid_q;

	vpa_pkg::blk_t ve;
	logic          skip;
	logic          in_range;
	logic          cand;
	logic          take;
	logic          own_hit;
	logic          next_hit;
	logic          id_valid;
	logic          cfg_pool_wr;
	logic [SW-1:0] pool_v;

	logic [IW-1:0] g0_c;
	logic [1:0]    dcnt_c;
	logic [SW:0]   glen_sum;
	logic [AW-1:0] gbase_c;
	logic [SW-1:0] spare;
	logic [SW:0]   grow_sum;
	logic [SW-1:0] extra;
	logic [IW-1:0] own_p1;
	logic          cnt_full;
	logic          pick_split;
	vpa_pkg::blk_t tail_ent;
	vpa_pkg::blk_t pick_own_ent;
	vpa_pkg::blk_t own_need_ent;
	logic [IW-1:0] pick_adj;
	logic [CW-1:0] cnt_merged;
	vpa_pkg::blk_t merged_ent;

	vpa_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.head   (head)
	);

	assign id_valid    = var_valid_q[id_q];
	assign cfg_pool_wr = (state_q == S_IDLE) && cfg_we && (cfg_idx == vpa_pkg::CFG_POOL);

	always_comb begin
		pool_v = cfg_data;
		if (cfg_data == '0) pool_v = SW'(1);
		else if (cfg_data > SW'(vpa_pkg::POOL_MAX)) pool_v = SW'(vpa_pkg::POOL_MAX);
	end

	// scan view: in the second pass the freed group reads as one vacant block
	always_comb begin
		ve   = head;
		skip = 1'b0;
		if (pass2_q) begin
			if (j_q == g0_q) begin
				ve.vacant = 1'b1;
				ve.owner  = '0;
				ve.base   = gbase_q;
				ve.len    = glen_q;
			end else if (j_q > g0_q && j_q <= g1_q) begin
				skip = 1'b1;
			end
		end
		in_range = {1'b0, j_q} < blk_cnt_q;
		cand     = in_range && !skip && ve.vacant && (ve.len >= need_q);
		take     = cand && (!pick_found_q ||
			(fit_q == vpa_pkg::FIT_BEST && ve.len < pick_len_q) ||
			(fit_q == vpa_pkg::FIT_WORST && ve.len > pick_len_q));
		own_hit  = !pass2_q && in_range && !head.vacant && (head.owner == id_q);
		next_hit = !pass2_q && in_range && own_found_q &&
			({1'b0, j_q} == ({1'b0, own_idx_q} + CW'(1)));
	end

	always_comb begin
		dcnt_c   = {1'b0, prev_vac_q} + {1'b0, next_vac_q};
		g0_c     = own_idx_q - IW'(prev_vac_q);
		glen_sum = {1'b0, own_len_q} + (prev_vac_q ? {1'b0, prev_len_q} : '0) +
			(next_vac_q ? {1'b0, next_len_q} : '0);
		gbase_c  = prev_vac_q ? prev_base_q : own_base_q;
		spare    = own_len_q - need_q;
		grow_sum = {1'b0, own_len_q} + {1'b0, next_len_q};
		extra    = need_q - own_len_q;
		own_p1   = own_idx_q + IW'(1);
		cnt_full = blk_cnt_q == CW'(vpa_pkg::MAX_BLOCKS);
		pick_split = pick_len_q > need_q;
		cnt_merged = blk_cnt_q - CW'(dcnt_q);
		pick_adj   = (pick_idx_q > g0_q) ? (pick_idx_q - IW'(dcnt_q)) : pick_idx_q;

		tail_ent.vacant = 1'b1;
		tail_ent.owner  = '0;
		tail_ent.base   = pick_base_q + need_q[AW-1:0];
		tail_ent.len    = pick_len_q - need_q;

		pick_own_ent.vacant = 1'b0;
		pick_own_ent.owner  = id_q;
		pick_own_ent.base   = pick_base_q;
		pick_own_ent.len    = need_q;

		own_need_ent.vacant = 1'b0;
		own_need_ent.owner  = id_q;
		own_need_ent.base   = own_base_q;
		own_need_ent.len    = need_q;

		merged_ent.vacant = 1'b1;
		merged_ent.owner  = '0;
		merged_ent.base   = gbase_q;
		merged_ent.len    = glen_q;
	end

	always_comb begin
		ctl.op   = vpa_pkg::CH_HOLD;
		ctl.pos  = '0;
		ctl.data = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cfg_pool_wr) begin
					ctl.op          = vpa_pkg::CH_WRITE;
					ctl.data.vacant = 1'b1;
					ctl.data.len    = pool_v;
				end
			end
			S_SCAN: ctl.op = vpa_pkg::CH_ROT;
			S_EDIT: begin
				priority if (merge_q) begin
					ctl.op   = vpa_pkg::CH_WRITE;
					ctl.pos  = g0_q;
					ctl.data = merged_ent;
				end else if (del_n_q != '0) begin
					ctl.op  = vpa_pkg::CH_DEL;
					ctl.pos = g0_q + IW'(1);
				end else if (ins_q) begin
					ctl.op   = vpa_pkg::CH_INS;
					ctl.pos  = ins_pos_q;
					ctl.data = ins_data_q;
				end else if (w1_q) begin
					ctl.op   = vpa_pkg::CH_WRITE;
					ctl.pos  = w1_pos_q;
					ctl.data = w1_data_q;
				end else if (w2_q) begin
					ctl.op   = vpa_pkg::CH_WRITE;
					ctl.pos  = w2_pos_q;
					ctl.data = w2_data_q;
				end else if (del2_q) begin
					ctl.op  = vpa_pkg::CH_DEL;
					ctl.pos = del2_pos_q;
				end
			end
			S_DECIDE, S_PLAN_MOVE, S_DONE: ctl.op = vpa_pkg::CH_HOLD;
			default: ctl.op = vpa_pkg::CH_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fit_q        <= vpa_pkg::FIT_FIRST;
			blk_cnt_q    <= CW'(1);
			var_valid_q  <= '0;
			var_cnt_q    <= '0;
			op_q         <= vpa_pkg::OP_ALLOC;
			id_q         <= '0;
			need_q       <= '0;
			j_q          <= '0;
			pass2_q      <= 1'b0;
			own_found_q  <= 1'b0;
			own_idx_q    <= '0;
			own_base_q   <= '0;
			own_len_q    <= '0;
			prev_vac_q   <= 1'b0;
			prev_base_q  <= '0;
			prev_len_q   <= '0;
			next_vac_q   <= 1'b0;
			next_base_q  <= '0;
			next_len_q   <= '0;
			last_vac_q   <= 1'b0;
			last_base_q  <= '0;
			last_len_q   <= '0;
			pick_found_q <= 1'b0;
			pick_idx_q   <= '0;
			pick_base_q  <= '0;
			pick_len_q   <= '0;
			g0_q         <= '0;
			g1_q         <= '0;
			dcnt_q       <= '0;
			glen_q       <= '0;
			gbase_q      <= '0;
			merge_q      <= 1'b0;
			del_n_q      <= '0;
			ins_q        <= 1'b0;
			ins_pos_q    <= '0;
			ins_data_q   <= '0;
			w1_q         <= 1'b0;
			w1_pos_q     <= '0;
			w1_data_q    <= '0;
			w2_q         <= 1'b0;
			w2_pos_q     <= '0;
			w2_data_q    <= '0;
			del2_q       <= 1'b0;
			del2_pos_q   <= '0;
			res_q        <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (cfg_we && cfg_idx == vpa_pkg::CFG_FIT) fit_q <= cfg_data[1:0];
					if (cfg_pool_wr) begin
						blk_cnt_q   <= CW'(1);
						var_valid_q <= '0;
						var_cnt_q   <= '0;
					end
					if (in_valid) begin
						op_q         <= in_data.op;
						id_q         <= in_data.var_id;
						need_q       <= in_data.req_size;
						j_q          <= '0;
						pass2_q      <= 1'b0;
						own_found_q  <= 1'b0;
						prev_vac_q   <= 1'b0;
						next_vac_q   <= 1'b0;
						last_vac_q   <= 1'b0;
						pick_found_q <= 1'b0;
						merge_q      <= 1'b0;
						del_n_q      <= '0;
						ins_q        <= 1'b0;
						w1_q         <= 1'b0;
						w2_q         <= 1'b0;
						del2_q       <= 1'b0;
						state_q      <= S_SCAN;
					end
				end

				S_SCAN: begin
					last_vac_q  <= head.vacant;
					last_base_q <= head.base;
					last_len_q  <= head.len;
					if (own_hit) begin
						own_found_q <= 1'b1;
						own_idx_q   <= j_q;
						own_base_q  <= head.base;
						own_len_q   <= head.len;
						prev_vac_q  <= (j_q != '0) && last_vac_q;
						prev_base_q <= last_base_q;
						prev_len_q  <= last_len_q;
					end
					if (next_hit) begin
						next_vac_q  <= head.vacant;
						next_base_q <= head.base;
						next_len_q  <= head.len;
					end
					if (take) begin
						pick_found_q <= 1'b1;
						pick_idx_q   <= j_q;
						pick_base_q  <= ve.base;
						pick_len_q   <= ve.len;
					end
					j_q <= j_q + IW'(1);
					if (j_q == IW'(vpa_pkg::MAX_BLOCKS - 1)) begin
						state_q <= pass2_q ? S_PLAN_MOVE : S_DECIDE;
					end
				end

				S_DECIDE: begin
					g0_q    <= g0_c;
					g1_q    <= g0_c + IW'(dcnt_c);
					dcnt_q  <= dcnt_c;
					glen_q  <= glen_sum[SW-1:0];
					gbase_q <= gbase_c;
					unique case (op_q)
						vpa_pkg::OP_ALLOC: begin
							if (id_valid) begin
								res_q   <= {vpa_pkg::ST_EXISTS, own_base_q, own_len_q};
								state_q <= S_DONE;
							end else if (var_cnt_q == vpa_pkg::VAR_CNT_W'(vpa_pkg::MAX_VARS)) begin
								res_q   <= {vpa_pkg::ST_FULL, {AW{1'b0}}, {SW{1'b0}}};
								state_q <= S_DONE;
							end else if (!pick_found_q || (pick_split && cnt_full)) begin
								res_q   <= {vpa_pkg::ST_NOSPACE, {AW{1'b0}}, {SW{1'b0}}};
								state_q <= S_DONE;
							end else begin
								ins_q       <= pick_split;
								ins_pos_q   <= pick_idx_q + IW'(1);
								ins_data_q  <= tail_ent;
								w1_q        <= 1'b1;
								w1_pos_q    <= pick_idx_q;
								w1_data_q   <= pick_own_ent;
								var_valid_q[id_q] <= 1'b1;
								var_cnt_q   <= var_cnt_q + vpa_pkg::VAR_CNT_W'(1);
								res_q       <= {vpa_pkg::ST_OK, pick_base_q, need_q};
								state_q     <= S_EDIT;
							end
						end
						vpa_pkg::OP_RESIZE: begin
							if (!id_valid) begin
								res_q   <= {vpa_pkg::ST_UNKNOWN, {AW{1'b0}}, {SW{1'b0}}};
								state_q <= S_DONE;
							end else if (need_q <= own_len_q) begin
								if (spare == '0) begin
									res_q   <= {vpa_pkg::ST_OK, own_base_q, need_q};
									state_q <= S_DONE;
								end else if (next_vac_q) begin
									w1_q             <= 1'b1;
									w1_pos_q         <= own_p1;
									w1_data_q.vacant <= 1'b1;
									w1_data_q.owner  <= '0;
									w1_data_q.base   <= next_base_q - spare[AW-1:0];
									w1_data_q.len    <= next_len_q + spare;
									w2_q             <= 1'b1;
									w2_pos_q         <= own_idx_q;
									w2_data_q        <= own_need_ent;
									res_q            <= {vpa_pkg::ST_OK, own_base_q, need_q};
									state_q          <= S_EDIT;
								end else if (cnt_full) begin
									res_q   <= {vpa_pkg::ST_NOSPACE, own_base_q, own_len_q};
									state_q <= S_DONE;
								end else begin
									ins_q             <= 1'b1;
									ins_pos_q         <= own_p1;
									ins_data_q.vacant <= 1'b1;
									ins_data_q.owner  <= '0;
									ins_data_q.base   <= own_base_q + need_q[AW-1:0];
									ins_data_q.len    <= spare;
									w1_q              <= 1'b1;
									w1_pos_q          <= own_idx_q;
									w1_data_q         <= own_need_ent;
									res_q             <= {vpa_pkg::ST_OK, own_base_q, need_q};
									state_q           <= S_EDIT;
								end
							end else if (next_vac_q && grow_sum >= {1'b0, need_q}) begin
								w1_q      <= 1'b1;
								w1_pos_q  <= own_idx_q;
								w1_data_q <= own_need_ent;
								if (next_len_q == extra) begin
									del2_q     <= 1'b1;
									del2_pos_q <= own_p1;
								end else begin
									w2_q             <= 1'b1;
									w2_pos_q         <= own_p1;
									w2_data_q.vacant <= 1'b1;
									w2_data_q.owner  <= '0;
									w2_data_q.base   <= next_base_q + extra[AW-1:0];
									w2_data_q.len    <= next_len_q - extra;
								end
								res_q   <= {vpa_pkg::ST_OK, own_base_q, need_q};
								state_q <= S_EDIT;
							end else begin
								// move: rescan with the old block freed and merged
								pass2_q      <= 1'b1;
								j_q          <= '0;
								pick_found_q <= 1'b0;
								state_q      <= S_SCAN;
							end
						end
						vpa_pkg::OP_RELEASE: begin
							if (!id_valid) begin
								res_q   <= {vpa_pkg::ST_UNKNOWN, {AW{1'b0}}, {SW{1'b0}}};
								state_q <= S_DONE;
							end else begin
								merge_q           <= 1'b1;
								del_n_q           <= dcnt_c;
								var_valid_q[id_q] <= 1'b0;
								var_cnt_q         <= var_cnt_q - vpa_pkg::VAR_CNT_W'(1);
								res_q             <= {vpa_pkg::ST_OK, {AW{1'b0}}, {SW{1'b0}}};
								state_q           <= S_EDIT;
							end
						end
						default: begin
							res_q   <= {vpa_pkg::ST_UNKNOWN, {AW{1'b0}}, {SW{1'b0}}};
							state_q <= S_DONE;
						end
					endcase
				end

				S_PLAN_MOVE: begin
					if (!pick_found_q ||
						(pick_split && cnt_merged == CW'(vpa_pkg::MAX_BLOCKS))) begin
						res_q.status       <= vpa_pkg::ST_NOSPACE;
						res_q.address      <= own_base_q;
						res_q.granted_size <= own_len_q;
						state_q            <= S_DONE;
					end else begin
						merge_q    <= 1'b1;
						del_n_q    <= dcnt_q;
						ins_q      <= pick_split;
						ins_pos_q  <= pick_adj + IW'(1);
						ins_data_q <= tail_ent;
						w1_q       <= 1'b1;
						w1_pos_q   <= pick_adj;
						w1_data_q  <= pick_own_ent;
						res_q.status       <= vpa_pkg::ST_OK;
						res_q.address      <= pick_base_q;
						res_q.granted_size <= need_q;
						state_q    <= S_EDIT;
					end
				end

				S_EDIT: begin
					priority if (merge_q) begin
						merge_q <= 1'b0;
					end else if (del_n_q != '0) begin
						del_n_q   <= del_n_q - 2'd1;
						blk_cnt_q <= blk_cnt_q - CW'(1);
					end else if (ins_q) begin
						ins_q     <= 1'b0;
						blk_cnt_q <= blk_cnt_q + CW'(1);
					end else if (w1_q) begin
						w1_q <= 1'b0;
					end else if (w2_q) begin
						w2_q <= 1'b0;
					end else if (del2_q) begin
						del2_q    <= 1'b0;
						blk_cnt_q <= blk_cnt_q - CW'(1);
					end else begin
						state_q <= S_DONE;
					end
				end

				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_blk_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(blk_cnt_q != '0) && (blk_cnt_q <= CW'(vpa_pkg::MAX_BLOCKS)))
		else $error("block count out of range");

	a_var_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		var_cnt_q == vpa_pkg::VAR_CNT_W'($countones(var_valid_q)))
		else $error("variable count disagrees with valid bits");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_SCAN))
		else $error("accepted request did not start a scan");

endmodule

[hw/rtl/vpa_cell.sv]
module vpa_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [vpa_pkg::BLK_IDX_W-1:0]  idx,
	input  vpa_pkg::chain_ctl_t            ctl,
	input  vpa_pkg::blk_t                  prv,
	input  vpa_pkg::blk_t                  nxt,
	output vpa_pkg::blk_t                  q
);

	vpa_pkg::blk_t ent_q;
	vpa_pkg::blk_t ent_d;

	always_comb begin
		ent_d = ent_q;
		unique case (ctl.op)
			vpa_pkg::CH_HOLD: ent_d = ent_q;
			vpa_pkg::CH_ROT: ent_d = nxt;
			vpa_pkg::CH_WRITE: begin
				if (idx == ctl.pos) ent_d = ctl.data;
			end
			vpa_pkg::CH_INS: begin
				if (idx == ctl.pos) ent_d = ctl.data;
				else if (idx > ctl.pos) ent_d = prv;
			end
			vpa_pkg::CH_DEL: begin
				if (idx >= ctl.pos) ent_d = nxt;
			end
			default: ent_d = ent_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.vacant <= 1'b1;
			ent_q.owner  <= '0;
			ent_q.base   <= '0;
			ent_q.len    <= vpa_pkg::SIZE_W'(vpa_pkg::POOL_RESET);
		end else begin
			ent_q <= ent_d;
		end
	end

	assign q = ent_q;

endmodule

[hw/rtl/vpa_chain.sv]
module vpa_chain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vpa_pkg::chain_ctl_t  ctl,
	output vpa_pkg::blk_t        head
);

	vpa_pkg::blk_t cell_q [vpa_pkg::MAX_BLOCKS];

	for (genvar i = 0; i < vpa_pkg::MAX_BLOCKS; i++) begin : g_cell
		vpa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (vpa_pkg::BLK_IDX_W'(i)),
			.ctl    (ctl),
			.prv    (cell_q[(i + vpa_pkg::MAX_BLOCKS - 1) % vpa_pkg::MAX_BLOCKS]),
			.nxt    (cell_q[(i + 1) % vpa_pkg::MAX_BLOCKS]),
			.q      (cell_q[i])
		);
	end

	assign head = cell_q[0];

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	vpa_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	vpa_pkg::res_t out_data;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_idx = '0;
	logic [vpa_pkg::SIZE_W-1:0] cfg_data = '0;

	variable_pool_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	typedef struct {
		logic vacant;
		int owner;
		int base;
		int len;
	} seg_t;

	seg_t segs[$];
	seg_t segs_saved[$];
	bit var_live[vpa_pkg::ID_SPACE];
	int var_base[vpa_pkg::ID_SPACE];
	int var_len[vpa_pkg::ID_SPACE];
	int live_vars;
	logic [1:0] m_fit;
	int m_pool;

	vpa_pkg::req_t req_q[$];
	vpa_pkg::res_t grant_q[$];
	int errors = 0;
	int mismatches = 0;
	bit hold_out = 1'b0;
	bit sender_pause = 1'b0;

	function automatic void pool_rebuild();
		seg_t s;
		segs = {};
		s.vacant = 1'b1; s.owner = 0; s.base = 0; s.len = m_pool;
		segs.push_back(s);
		foreach (var_live[i]) begin
			var_live[i] = 1'b0; var_base[i] = 0; var_len[i] = 0;
		end
		live_vars = 0;
	endfunction

	function automatic void pool_config(int idx, int val);
		int v;
		if (idx == vpa_pkg::CFG_FIT) begin
			m_fit = val[1:0];
		end else begin
			v = val & 32'h7fff;
			if (v == 0) v = 1;
			if (v > vpa_pkg::POOL_MAX) v = vpa_pkg::POOL_MAX;
			m_pool = v;
			pool_rebuild();
		end
	endfunction

	function automatic int owner_of(int id);
		foreach (segs[i])
			if (!segs[i].vacant && segs[i].owner == id) return i;
		return -1;
	endfunction

	function automatic int pick_fit(int need);
		int p;
		p = -1;
		foreach (segs[i]) begin
			if (!segs[i].vacant || segs[i].len < need) continue;
			if (p < 0) begin
				p = i;
				if (m_fit != vpa_pkg::FIT_BEST && m_fit != vpa_pkg::FIT_WORST) return p;
			end else if (m_fit == vpa_pkg::FIT_BEST && segs[i].len < segs[p].len) begin
				p = i;
			end else if (m_fit == vpa_pkg::FIT_WORST && segs[i].len > segs[p].len) begin
				p = i;
			end
		end
		return p;
	endfunction

	function automatic bit add_after(int i, int base, int len);
		seg_t s;
		if (segs.size() >= vpa_pkg::MAX_BLOCKS) return 1'b0;
		s.vacant = 1'b1; s.owner = 0; s.base = base; s.len = len;
		segs.insert(i + 1, s);
		return 1'b1;
	endfunction

	function automatic void merge_vacant();
		int i;
		i = 0;
		while (i + 1 < segs.size()) begin
			if (segs[i].vacant && segs[i+1].vacant) begin
				segs[i].len += segs[i+1].len;
				segs.delete(i + 1);
			end else begin
				i++;
			end
		end
	endfunction

	function automatic bit take_seg(int i, int id, int need);
		if (segs[i].len > need) begin
			if (!add_after(i, segs[i].base + need, segs[i].len - need)) return 1'b0;
			segs[i].len = need;
		end
		segs[i].vacant = 1'b0;
		segs[i].owner = id;
		var_live[id] = 1'b1;
		var_base[id] = segs[i].base;
		var_len[id] = need;
		return 1'b1;
	endfunction

	function automatic vpa_pkg::status_t pool_alloc(int id, int need);
		int k;
		if (var_live[id]) return vpa_pkg::ST_EXISTS;
		if (live_vars >= vpa_pkg::MAX_VARS) return vpa_pkg::ST_FULL;
		k = pick_fit(need);
		if (k < 0) return vpa_pkg::ST_NOSPACE;
		if (!take_seg(k, id, need)) return vpa_pkg::ST_NOSPACE;
		live_vars++;
		return vpa_pkg::ST_OK;
	endfunction

	function automatic vpa_pkg::status_t pool_resize(int id, int need);
		int i, k, spare, extra;
		if (!var_live[id]) return vpa_pkg::ST_UNKNOWN;
		i = owner_of(id);
		if (i < 0) return vpa_pkg::ST_UNKNOWN;
		if (need <= segs[i].len) begin
			spare = segs[i].len - need;
			if (spare != 0) begin
				if (i + 1 < segs.size() && segs[i+1].vacant) begin
					segs[i+1].base -= spare;
					segs[i+1].len += spare;
				end else if (!add_after(i, segs[i].base + need, spare)) begin
					return vpa_pkg::ST_NOSPACE;
				end
				segs[i].len = need;
			end
			var_len[id] = need;
			return vpa_pkg::ST_OK;
		end
		if (i + 1 < segs.size() && segs[i+1].vacant &&
				segs[i].len + segs[i+1].len >= need) begin
			extra = need - segs[i].len;
			segs[i].len = need;
			segs[i+1].len -= extra;
			segs[i+1].base += extra;
			if (segs[i+1].len == 0) segs.delete(i + 1);
			var_len[id] = need;
			return vpa_pkg::ST_OK;
		end
		segs_saved = segs;
		segs[i].vacant = 1'b1;
		segs[i].owner = 0;
		merge_vacant();
		k = pick_fit(need);
		if (k < 0 || !take_seg(k, id, need)) begin
			segs = segs_saved;
			return vpa_pkg::ST_NOSPACE;
		end
		return vpa_pkg::ST_OK;
	endfunction

	function automatic vpa_pkg::status_t pool_release(int id);
		int k;
		if (!var_live[id]) return vpa_pkg::ST_UNKNOWN;
		k = owner_of(id);
		if (k >= 0) begin
			segs[k].vacant = 1'b1;
			segs[k].owner = 0;
			merge_vacant();
		end
		var_live[id] = 1'b0;
		var_base[id] = 0;
		var_len[id] = 0;
		if (live_vars > 0) live_vars--;
		return vpa_pkg::ST_OK;
	endfunction

	function automatic vpa_pkg::res_t pool_step(vpa_pkg::req_t r);
		vpa_pkg::res_t g;
		int id, need;
		id = r.var_id;
		need = r.req_size;
		case (r.op)
			vpa_pkg::OP_ALLOC: g.status = pool_alloc(id, need);
			vpa_pkg::OP_RESIZE: g.status = pool_resize(id, need);
			vpa_pkg::OP_RELEASE: g.status = pool_release(id);
			default: g.status = vpa_pkg::ST_UNKNOWN;
		endcase
		g.address = '0;
		g.granted_size = '0;
		if (r.op != vpa_pkg::OP_NONE && var_live[id]) begin
			g.address = var_base[id][vpa_pkg::ADDR_W-1:0];
			g.granted_size = var_len[id][vpa_pkg::SIZE_W-1:0];
		end
		return g;
	endfunction

	logic in_stall_seen = 1'b0;
	int out_gap = 0;

	// driver
	int in_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall_seen) begin
				in_valid <= 1'b0;
				in_gap = $urandom_range(0, 13);
				if ($urandom_range(0, 3) == 0) in_gap = 0;
			end else if (!in_valid) begin
				if (in_gap > 0) in_gap--;
				else if (!sender_pause && req_q.size() > 0) begin
					in_data <= req_q.pop_front();
					in_valid <= 1'b1;
				end
			end
		end
	end

	// accepted beats are predicted at the rising edge
	always @(posedge clk) begin
		in_stall_seen <= in_stall;
		if (arst_n && in_valid && !in_stall)
			grant_q.push_back(pool_step(in_data));
		if (arst_n && out_valid && !out_stall) begin
			if (grant_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result beat %p", out_data);
			end else if (grant_q[0] !== out_data) begin
				errors++;
				if (mismatches++ < 10)
					$display("mismatch: expected %p actual %p", grant_q[0], out_data);
				void'(grant_q.pop_front());
			end else begin
				void'(grant_q.pop_front());
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_out) begin
			out_stall <= 1'b1;
		end else if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (out_valid && !out_stall) begin
				out_gap = $urandom_range(0, 13);
				if ($urandom_range(0, 3) == 0) out_gap = 0;
				if (out_gap > 0) out_stall <= 1'b1;
			end
		end
	end

	task automatic push_req(vpa_pkg::op_t op, int id, int sz);
		vpa_pkg::req_t r;
		r.op = op;
		r.var_id = id[vpa_pkg::ID_W-1:0];
		r.req_size = sz[vpa_pkg::SIZE_W-1:0];
		req_q.push_back(r);
	endtask

	task automatic drain();
		while (req_q.size() > 0 || in_valid) @(posedge clk);
		while (grant_q.size() > 0) @(posedge clk);
		repeat (2 * vpa_pkg::MAX_BLOCKS + 20) @(posedge clk);
	endtask

	task automatic write_reg(int idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx[0:0];
		cfg_data <= val[vpa_pkg::SIZE_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		pool_config(idx, val);
	endtask

	task automatic random_phase(int n, int pool);
		int r, id, sz;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 23);
			case ($urandom_range(0, 9))
				0: sz = $urandom_range(0, 32767);
				1: sz = 0;
				2: sz = pool;
				default: sz = $urandom_range(0, pool / 8 + 1);
			endcase
			if (r < 40) push_req(vpa_pkg::OP_ALLOC, id, sz);
			else if (r < 70) push_req(vpa_pkg::OP_RESIZE, id, sz);
			else if (r < 97) push_req(vpa_pkg::OP_RELEASE, id, $urandom_range(0, 32767));
			else push_req(vpa_pkg::OP_NONE, id, sz);
		end
	endtask

	initial begin
		m_fit = vpa_pkg::FIT_FIRST;
		m_pool = vpa_pkg::POOL_RESET;
		pool_rebuild();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		push_req(vpa_pkg::OP_ALLOC, 0, 0);
		push_req(vpa_pkg::OP_ALLOC, 0, 5);
		push_req(vpa_pkg::OP_ALLOC, 127, 100);
		push_req(vpa_pkg::OP_ALLOC, 1, 16384);
		push_req(vpa_pkg::OP_ALLOC, 2, 32767);
		push_req(vpa_pkg::OP_RESIZE, 127, 50);
		push_req(vpa_pkg::OP_RESIZE, 127, 300);
		push_req(vpa_pkg::OP_ALLOC, 3, 200);
		push_req(vpa_pkg::OP_RESIZE, 127, 2000);
		push_req(vpa_pkg::OP_RESIZE, 5, 10);
		push_req(vpa_pkg::OP_RELEASE, 5, 0);
		push_req(vpa_pkg::OP_RELEASE, 0, 32767);
		push_req(vpa_pkg::OP_NONE, 3, 7);
		push_req(vpa_pkg::OP_ALLOC, 4, 9800);
		push_req(vpa_pkg::OP_RESIZE, 3, 9999);
		push_req(vpa_pkg::OP_RELEASE, 127, 0);
		push_req(vpa_pkg::OP_RELEASE, 3, 0);
		push_req(vpa_pkg::OP_RELEASE, 4, 0);
		push_req(vpa_pkg::OP_ALLOC, 6, 10000);
		drain();

		// fill the id table, long output hold meanwhile
		write_reg(vpa_pkg::CFG_POOL, 0);
		write_reg(vpa_pkg::CFG_POOL, 30000);
		for (int i = 0; i < 129; i++) push_req(vpa_pkg::OP_ALLOC, i % 128, 1);
		push_req(vpa_pkg::OP_ALLOC, 0, 0);
		hold_out = 1'b1;
		repeat (400) @(posedge clk);
		hold_out = 1'b0;
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			int pool;
			write_reg(vpa_pkg::CFG_FIT, ph % 4);
			pool = (ph == 7) ? vpa_pkg::POOL_MAX : (ph == 6 ? 1 : $urandom_range(40, 600));
			write_reg(vpa_pkg::CFG_POOL, pool);
			random_phase(60, pool);
			if (ph == 2) begin
				while (req_q.size() > 30) @(posedge clk);
				sender_pause = 1'b1;
				while (in_valid || grant_q.size() > 0) @(posedge clk);
				sender_pause = 1'b0;
			end
			drain();
		end

		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#40ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
